[rtl/core/voice_command_coalescing_scheduler_assert.svh]
// Assertion macros for the scheduler. The clock and reset of the including module are used.
`ifndef VOICE_COMMAND_COALESCING_SCHEDULER_ASSERT_SVH
`define VOICE_COMMAND_COALESCING_SCHEDULER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VCCS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");
`define VCCS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");
`else
`define VCCS_ASSERT_IMP(name, ante, cons)
`define VCCS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

[rtl/core/vccs_pkg.sv]
package vccs_pkg;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  cmd_opcode;
    logic [9:0]  cmd_voice;
    logic [15:0] cmd_generation;
    logic [8:0]  cmd_length;
    logic [15:0] cmd_tag;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        out_valid;
    logic [7:0]  out_opcode;
    logic [9:0]  out_voice;
    logic [15:0] out_generation;
    logic [4:0]  out_length;
    logic [15:0] out_tag;
    logic        out_coalesced;
    logic [8:0]  pending_total;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [9:0]  voice;
    logic [15:0] generation;
    logic [4:0]  length;
    logic [15:0] tag;
  } rec_t;

  localparam int RecW = $bits(rec_t);

  localparam logic [1:0] FN_ENQ  = 2'd0;
  localparam logic [1:0] FN_TAKE = 2'd1;
  localparam logic [1:0] FN_RET  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADLEN = 2'd3;

  localparam logic [7:0] OP_START = 8'h10;
  localparam logic [7:0] OP_STOP  = 8'h14;
  localparam logic [7:0] OP_KILL  = 8'h15;
  localparam logic [7:0] OP_REPL0 = 8'h16;
  localparam logic [7:0] OP_REPL2 = 8'h17;
  localparam logic [7:0] OP_REPL1 = 8'h18;

  function automatic logic is_life(input logic [7:0] op);
    return op == OP_START || op == OP_STOP || op == OP_KILL;
  endfunction

  function automatic logic is_repl(input logic [7:0] op);
    return op == OP_REPL0 || op == OP_REPL1 || op == OP_REPL2;
  endfunction

  function automatic logic [1:0] kind_of(input logic [7:0] op);
    logic [1:0] k;
    case (op)
      OP_REPL1: k = 2'd1;
      OP_REPL2: k = 2'd2;
      default:  k = 2'd0;
    endcase
    return k;
  endfunction

endpackage

[rtl/core/vccs_ram.sv]
module vccs_ram #(
  parameter int Width = 55,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/core/voice_command_coalescing_scheduler.sv]
// Voice command scheduler with per-voice coalescing slots.
// The input channel (in_valid_i, in_stall_o, in_word_i) carries one word per operation:
// enqueue, take or return to front. Every accepted word gives exactly one result word on
// the output channel (res_valid_o, res_stall_i, res_word_o).
// Records live in three synchronous RAMs: the lifecycle FIFO, the normal FIFO and the
// slot store with one entry per voice and replaceable kind; slot valid bits are flops.
// One operation is worked on at a time. A bad length or an unused function goes straight
// to the result register, a plain enqueue or return passes through the execute state, a
// start command first reads and checks the generations of its voice's three slots, and a
// take from a FIFO waits for the RAM read. A take served from the slots walks the valid
// bits one per cycle from the scan cursor before the read of the slot that it finds.
// The result register lets the next word be accepted while a result still waits.
// When the receiver stalls, the result holds and a finished second result waits inside,
// with in_stall_o high, until the register frees.
// Reset clears the FIFO pointers and counts, the slot valid bits and the scan cursor;
// no clearing pass is needed and the block accepts words right after reset.
`include "voice_command_coalescing_scheduler_assert.svh"
module voice_command_coalescing_scheduler #(
  parameter int VOICES       = 64,
  parameter int MAX_WORDS    = 16,
  parameter int LIFE_DEPTH   = 16,
  parameter int NORMAL_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vccs_pkg::in_word_t  in_word_i,
  output logic                res_valid_o,
  input  logic                res_stall_i,
  output vccs_pkg::out_word_t res_word_o
);
  import vccs_pkg::*;

  localparam int SlotCount = 3 * VOICES;
  localparam int SAW = $clog2(SlotCount);
  localparam int LAW = $clog2(LIFE_DEPTH);
  localparam int NAW = $clog2(NORMAL_DEPTH);
  localparam int LCW = $clog2(LIFE_DEPTH + 1);
  localparam int NCW = $clog2(NORMAL_DEPTH + 1);
  localparam int VCW = $clog2(SlotCount + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DROP_RD, S_DROP_CMP, S_EXEC, S_RDWAIT, S_SCAN, S_FINISH
  } state_e;

  typedef enum logic [1:0] {SRC_LIFE, SRC_NORM, SRC_SLOT} src_e;

  state_e               state_q, state_d;
  src_e                 src_q, src_d;
  in_word_t             cmd_q, cmd_d;
  logic [1:0]           k_q, k_d;
  logic [1:0]           status_q, status_d;
  logic                 valid_q, valid_d;
  logic                 coal_q, coal_d;
  rec_t                 got_q, got_d;
  logic [LAW-1:0]       life_head_q, life_head_d, life_tail_q, life_tail_d;
  logic [LCW-1:0]       life_count_q, life_count_d;
  logic [NAW-1:0]       norm_head_q, norm_head_d, norm_tail_q, norm_tail_d;
  logic [NCW-1:0]       norm_count_q, norm_count_d;
  logic [SlotCount-1:0] slot_valid_q, slot_valid_d;
  logic [VCW-1:0]       vcount_q, vcount_d;
  logic [SAW-1:0]       cursor_q, cursor_d;
  logic                 res_valid_q, res_valid_d;
  out_word_t            res_word_q, res_word_d;

  logic           life_we, norm_we, slot_we;
  logic [LAW-1:0] life_waddr, life_raddr;
  logic [NAW-1:0] norm_waddr, norm_raddr;
  logic [SAW-1:0] slot_waddr, slot_raddr;
  rec_t           life_rdata, norm_rdata, slot_rdata, cmd_rec;

  logic           voice_ok, in_voice_ok, in_bad_len, repl, life_full, norm_full;
  logic [SAW-1:0] slot_base, slot_idx, drop_idx, kill_idx;

  vccs_ram #(.Width(RecW), .Depth(LIFE_DEPTH)) u_life_ram (
    .clk_i(clk_i), .we_i(life_we), .waddr_i(life_waddr), .wdata_i(cmd_rec),
    .raddr_i(life_raddr), .rdata_o(life_rdata)
  );

  vccs_ram #(.Width(RecW), .Depth(NORMAL_DEPTH)) u_norm_ram (
    .clk_i(clk_i), .we_i(norm_we), .waddr_i(norm_waddr), .wdata_i(cmd_rec),
    .raddr_i(norm_raddr), .rdata_o(norm_rdata)
  );

  vccs_ram #(.Width(RecW), .Depth(SlotCount)) u_slot_ram (
    .clk_i(clk_i), .we_i(slot_we), .waddr_i(slot_waddr), .wdata_i(cmd_rec),
    .raddr_i(slot_raddr), .rdata_o(slot_rdata)
  );

  assign cmd_rec = '{cmd_q.cmd_opcode, cmd_q.cmd_voice, cmd_q.cmd_generation,
                     cmd_q.cmd_length[4:0], cmd_q.cmd_tag};
  assign voice_ok    = {1'b0, cmd_q.cmd_voice} < 11'(VOICES);
  assign in_voice_ok = {1'b0, in_word_i.cmd_voice} < 11'(VOICES);
  assign in_bad_len  = in_word_i.cmd_length == 9'd0 ||
                       {1'b0, in_word_i.cmd_length} > 10'(MAX_WORDS);
  assign slot_base   = SAW'((SAW+2)'(cmd_q.cmd_voice) * (SAW+2)'(3));
  assign slot_idx    = slot_base + SAW'(kind_of(cmd_q.cmd_opcode));
  assign drop_idx    = slot_base + SAW'(k_q);
  assign repl        = is_repl(cmd_q.cmd_opcode) && voice_ok;
  assign life_full   = life_count_q >= LCW'(LIFE_DEPTH);
  assign norm_full   = norm_count_q >= NCW'(NORMAL_DEPTH);

  assign in_stall_o  = state_q != S_IDLE;
  assign res_valid_o = res_valid_q;
  assign res_word_o  = res_word_q;

  always_comb begin
    state_d      = state_q;
    src_d        = src_q;
    cmd_d        = cmd_q;
    k_d          = k_q;
    status_d     = status_q;
    valid_d      = valid_q;
    coal_d       = coal_q;
    got_d        = got_q;
    life_head_d  = life_head_q;
    life_tail_d  = life_tail_q;
    life_count_d = life_count_q;
    norm_head_d  = norm_head_q;
    norm_tail_d  = norm_tail_q;
    norm_count_d = norm_count_q;
    slot_valid_d = slot_valid_q;
    vcount_d     = vcount_q;
    cursor_d     = cursor_q;
    res_word_d   = res_word_q;
    res_valid_d  = res_valid_q && res_stall_i;
    life_we      = 1'b0;
    norm_we      = 1'b0;
    slot_we      = 1'b0;
    life_waddr   = life_tail_q;
    life_raddr   = life_head_q;
    norm_waddr   = norm_tail_q;
    norm_raddr   = norm_head_q;
    slot_waddr   = slot_idx;
    slot_raddr   = drop_idx;
    kill_idx     = slot_base;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = in_word_i;
          k_d      = 2'd0;
          status_d = ST_OK;
          valid_d  = 1'b0;
          coal_d   = 1'b0;
          got_d    = '0;
          if (in_word_i.func == FN_ENQ || in_word_i.func == FN_RET) begin
            if (in_bad_len) begin
              status_d = ST_BADLEN;
              state_d  = S_FINISH;
            end else if (in_word_i.func == FN_ENQ && in_word_i.cmd_opcode == OP_START &&
                         in_voice_ok) begin
              state_d = S_DROP_RD;
            end else begin
              state_d = S_EXEC;
            end
          end else if (in_word_i.func == FN_TAKE) begin
            state_d = S_EXEC;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_DROP_RD: begin
        state_d = S_DROP_CMP;
      end
      S_DROP_CMP: begin
        if (slot_valid_q[drop_idx] && slot_rdata.generation != cmd_q.cmd_generation) begin
          slot_valid_d[drop_idx] = 1'b0;
          vcount_d = vcount_q - VCW'(1);
        end
        if (k_q == 2'd2) begin
          state_d = S_EXEC;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_DROP_RD;
        end
      end
      S_EXEC: begin
        state_d = S_FINISH;
        case (cmd_q.func)
          FN_ENQ: begin
            if (cmd_q.cmd_opcode == OP_KILL && voice_ok) begin
              for (int kk = 0; kk < 3; kk++) begin
                kill_idx = slot_base + SAW'(kk);
                if (slot_valid_d[kill_idx]) begin
                  slot_valid_d[kill_idx] = 1'b0;
                  vcount_d = vcount_d - VCW'(1);
                end
              end
            end
            if (repl) begin
              slot_we = 1'b1;
              coal_d  = slot_valid_q[slot_idx];
              if (!slot_valid_q[slot_idx]) begin
                slot_valid_d[slot_idx] = 1'b1;
                vcount_d = vcount_q + VCW'(1);
              end
            end else if (is_life(cmd_q.cmd_opcode)) begin
              if (life_full) begin
                status_d = ST_FULL;
              end else begin
                life_we      = 1'b1;
                life_tail_d  = (life_tail_q == LAW'(LIFE_DEPTH - 1)) ? '0
                               : life_tail_q + LAW'(1);
                life_count_d = life_count_q + LCW'(1);
              end
            end else begin
              if (norm_full) begin
                status_d = ST_FULL;
              end else begin
                norm_we      = 1'b1;
                norm_tail_d  = (norm_tail_q == NAW'(NORMAL_DEPTH - 1)) ? '0
                               : norm_tail_q + NAW'(1);
                norm_count_d = norm_count_q + NCW'(1);
              end
            end
          end
          FN_RET: begin
            if (is_life(cmd_q.cmd_opcode)) begin
              if (life_full) begin
                status_d = ST_FULL;
              end else begin
                life_we      = 1'b1;
                life_waddr   = (life_head_q == '0) ? LAW'(LIFE_DEPTH - 1)
                               : life_head_q - LAW'(1);
                life_head_d  = life_waddr;
                life_count_d = life_count_q + LCW'(1);
              end
            end else if (repl) begin
              slot_we = 1'b1;
              if (!slot_valid_q[slot_idx]) begin
                slot_valid_d[slot_idx] = 1'b1;
                vcount_d = vcount_q + VCW'(1);
              end
            end else begin
              if (norm_full) begin
                status_d = ST_FULL;
              end else begin
                norm_we      = 1'b1;
                norm_waddr   = (norm_head_q == '0) ? NAW'(NORMAL_DEPTH - 1)
                               : norm_head_q - NAW'(1);
                norm_head_d  = norm_waddr;
                norm_count_d = norm_count_q + NCW'(1);
              end
            end
          end
          FN_TAKE: begin
            if (life_count_q != '0) begin
              life_head_d  = (life_head_q == LAW'(LIFE_DEPTH - 1)) ? '0
                             : life_head_q + LAW'(1);
              life_count_d = life_count_q - LCW'(1);
              src_d        = SRC_LIFE;
              state_d      = S_RDWAIT;
            end else if (norm_count_q != '0) begin
              norm_head_d  = (norm_head_q == NAW'(NORMAL_DEPTH - 1)) ? '0
                             : norm_head_q + NAW'(1);
              norm_count_d = norm_count_q - NCW'(1);
              src_d        = SRC_NORM;
              state_d      = S_RDWAIT;
            end else if (vcount_q != '0) begin
              state_d = S_SCAN;
            end else begin
              status_d = ST_EMPTY;
            end
          end
          default: begin
            status_d = ST_OK;
          end
        endcase
      end
      S_SCAN: begin
        slot_raddr = cursor_q;
        cursor_d   = (cursor_q == SAW'(SlotCount - 1)) ? '0 : cursor_q + SAW'(1);
        if (slot_valid_q[cursor_q]) begin
          slot_valid_d[cursor_q] = 1'b0;
          vcount_d = vcount_q - VCW'(1);
          src_d    = SRC_SLOT;
          state_d  = S_RDWAIT;
        end
      end
      S_RDWAIT: begin
        case (src_q)
          SRC_LIFE: got_d = life_rdata;
          SRC_NORM: got_d = norm_rdata;
          default:  got_d = slot_rdata;
        endcase
        valid_d = 1'b1;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!res_valid_q || !res_stall_i) begin
          res_valid_d                = 1'b1;
          res_word_d.status          = status_q;
          res_word_d.out_valid       = valid_q;
          res_word_d.out_opcode      = got_q.opcode;
          res_word_d.out_voice       = got_q.voice;
          res_word_d.out_generation  = got_q.generation;
          res_word_d.out_length      = got_q.length;
          res_word_d.out_tag         = got_q.tag;
          res_word_d.out_coalesced   = coal_q;
          res_word_d.pending_total   = 9'(32'(life_count_q) + 32'(norm_count_q) +
                                          32'(vcount_q));
          state_d                    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      life_head_q  <= '0;
      life_tail_q  <= '0;
      life_count_q <= '0;
      norm_head_q  <= '0;
      norm_tail_q  <= '0;
      norm_count_q <= '0;
      slot_valid_q <= '0;
      vcount_q     <= '0;
      cursor_q     <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      life_head_q  <= life_head_d;
      life_tail_q  <= life_tail_d;
      life_count_q <= life_count_d;
      norm_head_q  <= norm_head_d;
      norm_tail_q  <= norm_tail_d;
      norm_count_q <= norm_count_d;
      slot_valid_q <= slot_valid_d;
      vcount_q     <= vcount_d;
      cursor_q     <= cursor_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    cmd_q      <= cmd_d;
    k_q        <= k_d;
    status_q   <= status_d;
    valid_q    <= valid_d;
    coal_q     <= coal_d;
    got_q      <= got_d;
    res_word_q <= res_word_d;
  end

  `VCCS_ASSERT_IMP(a_vcount_match, 1'b1, 32'(vcount_q) == 32'($countones(slot_valid_q)))
  `VCCS_ASSERT_IMP(a_life_bound, 1'b1, life_count_q <= LCW'(LIFE_DEPTH))
  `VCCS_ASSERT_IMP(a_taken_ok, res_valid_q, !res_word_q.out_valid || res_word_q.status == ST_OK)
  `VCCS_ASSERT_NEXT(a_finish_holds, state_q == S_FINISH && res_valid_q && res_stall_i, state_q == S_FINISH)

endmodule
